/* rtl/tpat_pkg.sv */
// shared types, constants and helpers of the tcp port address translator
package tpat_pkg;

    // table geometry
    localparam int unsigned TABLE_DEPTH = 65536;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

    // field widths
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 20;
    localparam int unsigned PLEN_W    = 6;
    localparam int unsigned ACT_W     = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // stream packing
    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 96;

    // port allocation wraps back to this value
    localparam logic [PORT_W-1:0] FIRST_PORT = 16'd10000;
    localparam logic [PORT_W-1:0] PORT_MAX   = 16'd65535;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PASS     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_OUT_HIT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OUT_NEW  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_IN_XLAT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IN_STALE = 3'd4;

    // request kinds
    localparam logic REQ_OUTBOUND = 1'b0;
    localparam logic REQ_INBOUND  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;

    // register reset values
    localparam logic [ADDR_W-1:0] PUBLIC_RST     = 32'd3232236042;
    localparam logic [ADDR_W-1:0] PREFIX_RST     = 32'd3232249856;
    localparam logic [PLEN_W-1:0] PREFIX_LEN_RST = 6'd24;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST    = 20'd60;

    // payload of one table entry
    typedef struct packed {
        logic [ADDR_W-1:0] lan_addr;
        logic [PORT_W-1:0] host_port;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    // outcome of the shared compare unit
    typedef struct packed {
        logic key_hit;
        logic stale;
    } t_match;

    // network mask for a prefix length, lengths above 32 act as 32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        logic [PLEN_W-1:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        if (l == 6'd0) begin
            return '0;
        end
        return {ADDR_W{1'b1}} << (6'd32 - l);
    endfunction

endpackage

/* rtl/tpat_table.sv */
// translation table: valid bits and entry payload, one write and one registered read port
module tpat_table (
    input  logic                       i_clk,
    input  logic [tpat_pkg::IDX_W-1:0] i_rd_addr,
    output logic                       o_rd_valid,
    output tpat_pkg::t_entry           o_rd_entry,
    input  logic [tpat_pkg::IDX_W-1:0] i_wr_addr,
    input  logic                       i_vld_we,
    input  logic                       i_vld_wdata,
    input  logic                       i_dat_we,
    input  tpat_pkg::t_entry           i_dat_wdata
);

    logic             r_vld_mem [tpat_pkg::TABLE_DEPTH];
    tpat_pkg::t_entry r_dat_mem [tpat_pkg::TABLE_DEPTH];

    // valid bit array
    always_ff @(posedge i_clk) begin
        if (i_vld_we) begin
            r_vld_mem[i_wr_addr] <= i_vld_wdata;
        end
        o_rd_valid <= r_vld_mem[i_rd_addr];
    end

    // payload array
    always_ff @(posedge i_clk) begin
        if (i_dat_we) begin
            r_dat_mem[i_wr_addr] <= i_dat_wdata;
        end
        o_rd_entry <= r_dat_mem[i_rd_addr];
    end

endmodule

/* rtl/tpat_match.sv */
// shared compare unit: key match against an entry and age check
module tpat_match (
    input  logic                         i_valid,
    input  tpat_pkg::t_entry             i_entry,
    input  logic [tpat_pkg::ADDR_W-1:0]  i_key_addr,
    input  logic [tpat_pkg::PORT_W-1:0]  i_key_port,
    input  logic [tpat_pkg::TIME_W-1:0]  i_now,
    input  logic [tpat_pkg::TMO_W-1:0]   i_timeout,
    output tpat_pkg::t_match             o_match
);

    logic [tpat_pkg::TIME_W-1:0] elapsed;

    // wrapping age of the entry
    assign elapsed = i_now - i_entry.stamp;

    // valid entry with matching lan address and port
    assign o_match.key_hit = i_valid && (i_entry.lan_addr == i_key_addr) &&
                             (i_entry.host_port == i_key_port);

    // older than the timeout
    assign o_match.stale = elapsed > {{(tpat_pkg::TIME_W - tpat_pkg::TMO_W){1'b0}}, i_timeout};

endmodule

/* rtl/tcp_port_address_translator.sv */
// tcp port address translator top level: sequencer, registers and stream ports
//
// One packet header enters on the s_axis channel (tdata: src_addr, src_port,
// dst_addr, dst_port, now_seconds; tuser: req_type, is_tcp). Exactly one result
// leaves on the m_axis channel (tdata: new src/dst address and port; tuser:
// action). Registers are written through a plain write port; the user is to
// write them only while idle, the block does not enforce it. After reset the
// block sweeps the table once to clear all valid bits, with tready low;
// register writes are taken meanwhile. A header takes one sequencer pass
// through the single table read port: passed packets go from classify to the
// result register, inbound packets read their slot first, and outbound lan
// packets check one table entry per cycle up to the first match, at most
// 65536 entries, then allocate if none matched live. A new header is accepted
// only once the previous one is finished, as its result is loaded. The result
// waits in an output register; a stalled receiver holds the next result in the
// sequencer until the register frees, and input stays not ready meanwhile.
module tcp_port_address_translator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // header input beat
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // src_addr[31:0], src_port[47:32], dst_addr[79:48], dst_port[95:80], now_seconds[127:96]
    input  logic [tpat_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // req_type[0], is_tcp[1]
    input  logic [tpat_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // result beat
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // new_src_addr[31:0], new_src_port[47:32], new_dst_addr[79:48], new_dst_port[95:80]
    output logic [tpat_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // action[2:0]
    output logic [tpat_pkg::ACT_W-1:0]          o_m_axis_tuser,
    // register write port
    input  logic                                i_cfg_we,
    input  logic [tpat_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [tpat_pkg::CFG_DAT_W-1:0]      i_cfg_wdata
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_ALLOC  = 3'd4;
    localparam logic [2:0] S_INB    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                   r_state, n_state;

    // configuration
    logic                         r_enable;
    logic [tpat_pkg::ADDR_W-1:0]  r_public;
    logic [tpat_pkg::ADDR_W-1:0]  r_prefix;
    logic [tpat_pkg::PLEN_W-1:0]  r_prefix_len;
    logic [tpat_pkg::TMO_W-1:0]   r_timeout;

    // working copy of the header, rewritten in place
    logic                         r_req, n_req;
    logic                         r_tcp, n_tcp;
    logic [tpat_pkg::ADDR_W-1:0]  r_saddr, n_saddr;
    logic [tpat_pkg::PORT_W-1:0]  r_sport, n_sport;
    logic [tpat_pkg::ADDR_W-1:0]  r_daddr, n_daddr;
    logic [tpat_pkg::PORT_W-1:0]  r_dport, n_dport;
    logic [tpat_pkg::TIME_W-1:0]  r_now, n_now;
    logic [tpat_pkg::ACT_W-1:0]   r_action, n_action;

    // scan and allocation
    logic [tpat_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [tpat_pkg::IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic                         r_chk_valid, n_chk_valid;
    logic [tpat_pkg::PORT_W-1:0]  r_next_port, n_next_port;

    // output register
    logic                         r_o_valid, n_o_valid;
    logic [tpat_pkg::OUT_DATA_W-1:0] r_o_data, n_o_data;
    logic [tpat_pkg::ACT_W-1:0]   r_o_user, n_o_user;

    // table ports
    logic [tpat_pkg::IDX_W-1:0]   rd_addr;
    logic                         rd_valid;
    tpat_pkg::t_entry             rd_entry;
    logic [tpat_pkg::IDX_W-1:0]   wr_addr;
    logic                         vld_we;
    logic                         vld_wdata;
    logic                         dat_we;
    tpat_pkg::t_entry             dat_wdata;
    tpat_pkg::t_match             match;

    logic [tpat_pkg::ADDR_W-1:0]  mask;
    logic                         in_beat;
    logic                         out_free;

    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;
    assign mask            = tpat_pkg::prefix_mask(r_prefix_len);

    // scan walks the table, inbound reads the slot named by the port
    assign rd_addr = (r_state == S_SCAN) ? r_idx : r_dport;

    tpat_table u_table (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_valid  (rd_valid),
        .o_rd_entry  (rd_entry),
        .i_wr_addr   (wr_addr),
        .i_vld_we    (vld_we),
        .i_vld_wdata (vld_wdata),
        .i_dat_we    (dat_we),
        .i_dat_wdata (dat_wdata)
    );

    tpat_match u_match (
        .i_valid    (rd_valid),
        .i_entry    (rd_entry),
        .i_key_addr (r_saddr),
        .i_key_port (r_sport),
        .i_now      (r_now),
        .i_timeout  (r_timeout),
        .o_match    (match)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_public     <= tpat_pkg::PUBLIC_RST;
            r_prefix     <= tpat_pkg::PREFIX_RST;
            r_prefix_len <= tpat_pkg::PREFIX_LEN_RST;
            r_timeout    <= tpat_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tpat_pkg::CFG_ENABLE:     r_enable     <= i_cfg_wdata[0];
                tpat_pkg::CFG_PUBLIC:     r_public     <= i_cfg_wdata;
                tpat_pkg::CFG_PREFIX:     r_prefix     <= i_cfg_wdata;
                tpat_pkg::CFG_PREFIX_LEN: r_prefix_len <= i_cfg_wdata[tpat_pkg::PLEN_W-1:0];
                tpat_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_wdata[tpat_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_tcp       = r_tcp;
        n_saddr     = r_saddr;
        n_sport     = r_sport;
        n_daddr     = r_daddr;
        n_dport     = r_dport;
        n_now       = r_now;
        n_action    = r_action;
        n_idx       = r_idx;
        n_chk_idx   = r_chk_idx;
        n_chk_valid = r_chk_valid;
        n_next_port = r_next_port;
        n_o_valid   = r_o_valid && !i_m_axis_tready;
        n_o_data    = r_o_data;
        n_o_user    = r_o_user;
        wr_addr     = r_chk_idx;
        vld_we      = 1'b0;
        vld_wdata   = 1'b0;
        dat_we      = 1'b0;
        dat_wdata   = '{lan_addr: r_saddr, host_port: r_sport, stamp: r_now};

        unique case (r_state)
            // clearing pass over all valid bits
            S_CLEAR: begin
                wr_addr = r_idx;
                vld_we  = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == {tpat_pkg::IDX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            // take a header beat
            S_IDLE: begin
                if (in_beat) begin
                    n_req    = i_s_axis_tuser[0];
                    n_tcp    = i_s_axis_tuser[1];
                    n_saddr  = i_s_axis_tdata[31:0];
                    n_sport  = i_s_axis_tdata[47:32];
                    n_daddr  = i_s_axis_tdata[79:48];
                    n_dport  = i_s_axis_tdata[95:80];
                    n_now    = i_s_axis_tdata[127:96];
                    n_action = tpat_pkg::ACT_PASS;
                    n_state  = S_DECIDE;
                end
            end
            // classify; inbound read of the slot is issued here
            S_DECIDE: begin
                n_idx       = '0;
                n_chk_valid = 1'b0;
                n_state     = S_OUT;
                if (r_enable && r_tcp) begin
                    if (r_req == tpat_pkg::REQ_OUTBOUND) begin
                        if ((r_saddr & mask) == (r_prefix & mask)) begin
                            n_state = S_SCAN;
                        end
                    end else if (r_daddr == r_public) begin
                        n_state = S_INB;
                    end
                end
            end
            // one read issued and one entry checked per cycle
            S_SCAN: begin
                n_idx       = r_idx + 1'b1;
                n_chk_idx   = r_idx;
                n_chk_valid = 1'b1;
                if (r_chk_valid && match.key_hit) begin
                    if (match.stale) begin
                        wr_addr = r_chk_idx;
                        vld_we  = 1'b1;
                        n_state = S_ALLOC;
                    end else begin
                        n_sport  = r_chk_idx;
                        n_saddr  = r_public;
                        n_action = tpat_pkg::ACT_OUT_HIT;
                        n_state  = S_OUT;
                    end
                end else if (r_chk_valid && (r_chk_idx == {tpat_pkg::IDX_W{1'b1}})) begin
                    n_state = S_ALLOC;
                end
            end
            // new entry at the next port of the allocation counter
            S_ALLOC: begin
                wr_addr   = r_next_port;
                vld_we    = 1'b1;
                vld_wdata = 1'b1;
                dat_we    = 1'b1;
                n_sport   = r_next_port;
                n_saddr   = r_public;
                n_action  = tpat_pkg::ACT_OUT_NEW;
                n_state   = S_OUT;
                if (r_next_port == tpat_pkg::PORT_MAX) begin
                    n_next_port = tpat_pkg::FIRST_PORT;
                end else begin
                    n_next_port = r_next_port + 1'b1;
                end
            end
            // inbound slot data is back
            S_INB: begin
                wr_addr = r_dport;
                n_state = S_OUT;
                if (rd_valid) begin
                    if (match.stale) begin
                        vld_we   = 1'b1;
                        n_action = tpat_pkg::ACT_IN_STALE;
                    end else begin
                        n_daddr  = rd_entry.lan_addr;
                        n_dport  = rd_entry.host_port;
                        n_action = tpat_pkg::ACT_IN_XLAT;
                    end
                end
            end
            // hand the result to the output register
            S_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {r_dport, r_daddr, r_sport, r_saddr};
                    n_o_user  = r_action;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_chk_valid <= 1'b0;
            r_next_port <= tpat_pkg::FIRST_PORT;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_chk_valid <= n_chk_valid;
            r_next_port <= n_next_port;
            r_o_valid   <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_tcp     <= n_tcp;
        r_saddr   <= n_saddr;
        r_sport   <= n_sport;
        r_daddr   <= n_daddr;
        r_dport   <= n_dport;
        r_now     <= n_now;
        r_action  <= n_action;
        r_chk_idx <= n_chk_idx;
        r_o_data  <= n_o_data;
        r_o_user  <= n_o_user;
    end

    // an accepted beat always starts classification
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_DECIDE))
        else $error("accepted beat did not start classification");

    // each allocation moves the port counter
    a_alloc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_next_port != $past(r_next_port)))
        else $error("allocation did not advance the port counter");

    // a finished result reaches the output register when it is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=> (o_m_axis_tvalid && (r_state == S_IDLE)))
        else $error("result not loaded into free output register");

    // payload writes only happen during allocation
    a_dat_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dat_we |-> ((r_state == S_ALLOC) && vld_we && vld_wdata))
        else $error("entry payload written outside allocation");

endmodule
